// File: design/tev_pkg.sv
package tev_pkg;

    localparam int NUM_OFFSETS = 12;
    localparam int NUM_EVENTS  = 2 * NUM_OFFSETS;
    localparam int EVT_IDX_W   = $clog2(NUM_EVENTS);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int APB_ADDR_W  = 6;
    localparam int APB_DATA_W  = 64;

    localparam logic [11:0] DEFAULT_NOMINAL = 12'h0a95;
    localparam logic [15:0] OVERRIDE_UNSET  = 16'hFFFF;
    localparam logic [47:0] THRESHOLD_RESET = 48'hFFFFFF000000;
    localparam logic [11:0] MASK12          = 12'h0fff;
    localparam logic [8:0]  NOMINAL_UNSPEC  = 9'd256;

    localparam logic DIR_ASSERT   = 1'b0;
    localparam logic DIR_DEASSERT = 1'b1;

    typedef enum logic [1:0] {
        KIND_READING = 2'd0,
        KIND_UNAVAIL = 2'd1,
        KIND_REARM   = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        REG_THRESHOLD_LEVELS  = 3'd0,
        REG_HYSTERESIS_LEVELS = 3'd1,
        REG_SUPPORTED_ASSERT  = 3'd2,
        REG_SUPPORTED_DEASSERT = 3'd3,
        REG_ENABLED_ASSERT    = 3'd4,
        REG_ENABLED_DEASSERT  = 3'd5,
        REG_NOMINAL_OVERRIDE  = 3'd6,
        REG_NOMINAL_READING   = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [47:0] threshold_levels;
        logic [15:0] hysteresis_levels;
        logic [11:0] supported_assert_mask;
        logic [11:0] supported_deassert_mask;
        logic [11:0] enabled_assert_mask;
        logic [11:0] enabled_deassert_mask;
        logic [15:0] nominal_override;
        logic [8:0]  nominal_reading;
    } cfg_t;

    typedef struct packed {
        logic [11:0] as_hit;
        logic [11:0] de_hit;
    } cmp_t;

    typedef struct packed {
        logic [7:0]            reading;
        logic [NUM_EVENTS-1:0] events;
        logic [11:0]           asserted;
        logic [11:0]           context_mask;
    } work_t;

    typedef struct packed {
        logic        is_event;
        logic        direction;
        logic [3:0]  event_offset;
        logic [7:0]  event_reading;
        logic [7:0]  event_threshold;
        logic [11:0] asserted_out;
        logic [11:0] context_out;
        logic        last;
    } result_t;

endpackage

// File: design/tev_if.sv
interface tev_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  reading;
    logic [11:0] context_in;
    logic [11:0] forced_asserts;
    logic [11:0] forced_deasserts;

    modport source (
        output valid, kind, reading, context_in, forced_asserts, forced_deasserts,
        input  ready
    );
    modport sink (
        input  valid, kind, reading, context_in, forced_asserts, forced_deasserts,
        output ready
    );
endinterface

interface tev_out_if;
    logic        valid;
    logic        ready;
    logic        is_event;
    logic        direction;
    logic [3:0]  event_offset;
    logic [7:0]  event_reading;
    logic [7:0]  event_threshold;
    logic [11:0] asserted_out;
    logic [11:0] context_out;
    logic        last;

    modport source (
        output valid, is_event, direction, event_offset, event_reading,
               event_threshold, asserted_out, context_out, last,
        input  ready
    );
    modport sink (
        input  valid, is_event, direction, event_offset, event_reading,
               event_threshold, asserted_out, context_out, last,
        output ready
    );
endinterface

// File: design/tev_regs.sv
module tev_regs
    import tev_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;
    assign idx    = reg_idx_t'(paddr[APB_ADDR_W-1:3]);
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_THRESHOLD_LEVELS:   cfg_next.threshold_levels = pwdata[47:0];
                REG_HYSTERESIS_LEVELS:  cfg_next.hysteresis_levels = pwdata[15:0];
                REG_SUPPORTED_ASSERT:   cfg_next.supported_assert_mask = pwdata[11:0];
                REG_SUPPORTED_DEASSERT: cfg_next.supported_deassert_mask = pwdata[11:0];
                REG_ENABLED_ASSERT:     cfg_next.enabled_assert_mask = pwdata[11:0];
                REG_ENABLED_DEASSERT:   cfg_next.enabled_deassert_mask = pwdata[11:0];
                REG_NOMINAL_OVERRIDE:   cfg_next.nominal_override = pwdata[15:0];
                REG_NOMINAL_READING:    cfg_next.nominal_reading = pwdata[8:0];
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_THRESHOLD_LEVELS:   prdata = {16'd0, cfg_reg.threshold_levels};
            REG_HYSTERESIS_LEVELS:  prdata = {48'd0, cfg_reg.hysteresis_levels};
            REG_SUPPORTED_ASSERT:   prdata = {52'd0, cfg_reg.supported_assert_mask};
            REG_SUPPORTED_DEASSERT: prdata = {52'd0, cfg_reg.supported_deassert_mask};
            REG_ENABLED_ASSERT:     prdata = {52'd0, cfg_reg.enabled_assert_mask};
            REG_ENABLED_DEASSERT:   prdata = {52'd0, cfg_reg.enabled_deassert_mask};
            REG_NOMINAL_OVERRIDE:   prdata = {48'd0, cfg_reg.nominal_override};
            REG_NOMINAL_READING:    prdata = {55'd0, cfg_reg.nominal_reading};
            default:                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold_levels        <= THRESHOLD_RESET;
            cfg_reg.hysteresis_levels       <= 16'd0;
            cfg_reg.supported_assert_mask   <= MASK12;
            cfg_reg.supported_deassert_mask <= MASK12;
            cfg_reg.enabled_assert_mask     <= MASK12;
            cfg_reg.enabled_deassert_mask   <= MASK12;
            cfg_reg.nominal_override        <= OVERRIDE_UNSET;
            cfg_reg.nominal_reading         <= NOMINAL_UNSPEC;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: design/tev_front.sv
module tev_front
    import tev_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  cfg_t     cfg,
    tev_in_if.sink   in_ch,
    output logic     push_valid,
    input  logic     push_ready,
    output work_t    push_data
);

    logic [11:0] asserted_reg;
    logic [11:0] asserted_next;
    logic [11:0] context_reg;
    logic [11:0] context_next;

    logic [11:0] nominal;
    logic [11:0] nomz;
    logic [11:0] st0;
    logic [11:0] blips;
    logic [11:0] fa;
    logic [11:0] fd;
    logic [11:0] as_new;
    logic [11:0] de_new;
    logic [11:0] st_new;
    logic [11:0] as_ev;
    logic [11:0] de_ev;
    logic [NUM_EVENTS-1:0] events;
    cmp_t        nom_cmp;
    cmp_t        rd_cmp;
    logic        accept;

    function automatic cmp_t compare_all(
        input logic [7:0]  val,
        input logic [47:0] thr_levels,
        input logic [15:0] hyst
    );
        cmp_t       r;
        logic [7:0] thr;
        r = '0;
        for (int b = 0; b < NUM_OFFSETS; b++)
        begin
            thr = thr_levels[8*(b/2) +: 8];
            if ((b % 2) == 1)
            begin
                r.as_hit[b] = (val >= thr);
                r.de_hit[b] = (({1'b0, val} + {1'b0, hyst[15:8]}) < {1'b0, thr});
            end
            else
            begin
                r.as_hit[b] = (val <= thr);
                r.de_hit[b] = ({1'b0, val} > ({1'b0, thr} + {1'b0, hyst[7:0]}));
            end
        end
        return r;
    endfunction

    assign in_ch.ready = push_ready;
    assign push_valid  = in_ch.valid;
    assign accept      = in_ch.valid & push_ready;

    always_comb
    begin
        nom_cmp = compare_all(cfg.nominal_reading[7:0], cfg.threshold_levels,
                              cfg.hysteresis_levels);
        rd_cmp  = compare_all(in_ch.reading, cfg.threshold_levels, cfg.hysteresis_levels);

        if (cfg.nominal_override != OVERRIDE_UNSET)
            nominal = cfg.nominal_override[11:0];
        else if (!cfg.nominal_reading[8])
            nominal = nom_cmp.as_hit;
        else
            nominal = DEFAULT_NOMINAL;

        nomz = (context_reg ^ in_ch.context_in) | ~in_ch.context_in;
        if (context_reg != in_ch.context_in)
            st0 = (asserted_reg & ~nomz) | (nomz & nominal);
        else
            st0 = asserted_reg;

        blips  = in_ch.forced_asserts & in_ch.forced_deasserts;
        fa     = in_ch.forced_asserts & (blips | ~st0);
        fd     = in_ch.forced_deasserts & (blips | st0);
        as_new = rd_cmp.as_hit & ~st0 & in_ch.context_in;
        de_new = rd_cmp.de_hit & st0 & in_ch.context_in;
        st_new = (st0 | as_new) & ~de_new;

        de_ev = (de_new | fd) & cfg.supported_deassert_mask & cfg.enabled_deassert_mask
                & in_ch.context_in;
        as_ev = (as_new | fa) & cfg.supported_assert_mask & cfg.enabled_assert_mask
                & in_ch.context_in;

        // deassertion before assertion within each offset
        for (int b = 0; b < NUM_OFFSETS; b++)
        begin
            events[2*b]     = de_ev[b];
            events[2*b + 1] = as_ev[b];
        end
    end

    always_comb
    begin
        asserted_next = asserted_reg;
        context_next  = context_reg;
        push_data.events = '0;
        case (in_ch.kind)
            KIND_READING:
            begin
                asserted_next    = st_new;
                context_next     = in_ch.context_in;
                push_data.events = events;
            end
            KIND_UNAVAIL:
            begin
                context_next = '0;
            end
            KIND_REARM:
            begin
                asserted_next = '0;
                context_next  = '0;
            end
            default:
            begin
                asserted_next = asserted_reg;
            end
        endcase
        push_data.reading      = in_ch.reading;
        push_data.asserted     = asserted_next;
        push_data.context_mask = context_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            asserted_reg <= '0;
            context_reg  <= '0;
        end
        else if (accept)
        begin
            asserted_reg <= asserted_next;
            context_reg  <= context_next;
        end
    end

endmodule

// File: design/tev_queue.sv
module tev_queue
    import tev_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push_valid,
    output logic  push_ready,
    input  work_t push_data,
    output logic  pop_valid,
    input  logic  pop,
    output work_t pop_data
);

    work_t             mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid & push_ready;
    assign do_pop     = pop & pop_valid;
    assign pop_data   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: design/tev_back.sv
module tev_back
    import tev_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [47:0] threshold_levels,
    input  logic        head_valid,
    input  work_t       head,
    output logic        pop,
    tev_out_if.source   out_ch
);

    logic [NUM_EVENTS-1:0] served_reg;
    logic [NUM_EVENTS-1:0] served_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    result_t               out_reg;
    result_t               out_next;

    logic [NUM_EVENTS-1:0] remain;
    logic                  has_evt;
    logic [EVT_IDX_W-1:0]  idx;
    logic                  load;

    assign remain  = head.events & ~served_reg;
    assign has_evt = |remain;
    assign load    = head_valid & (~out_valid_reg | out_ch.ready);
    assign pop     = load & ~has_evt;

    // lowest pending event first
    always_comb
    begin
        idx = '0;
        for (int i = NUM_EVENTS - 1; i >= 0; i--)
        begin
            if (remain[i])
                idx = EVT_IDX_W'(i);
        end
    end

    always_comb
    begin
        out_next    = '0;
        served_next = served_reg;
        if (has_evt)
        begin
            out_next.is_event        = 1'b1;
            out_next.direction       = idx[0] ? DIR_ASSERT : DIR_DEASSERT;
            out_next.event_offset    = idx[EVT_IDX_W-1:1];
            out_next.event_reading   = head.reading;
            out_next.event_threshold = threshold_levels[{idx[EVT_IDX_W-1:2], 3'b000} +: 8];
            if (load)
                served_next = served_reg | (NUM_EVENTS'(1) << idx);
        end
        else
        begin
            out_next.asserted_out = head.asserted;
            out_next.context_out  = head.context_mask;
            out_next.last         = 1'b1;
            if (load)
                served_next = '0;
        end

        if (load)
            out_valid_next = 1'b1;
        else if (out_ch.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            served_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            served_reg    <= served_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_ch.valid           = out_valid_reg;
    assign out_ch.is_event        = out_reg.is_event;
    assign out_ch.direction       = out_reg.direction;
    assign out_ch.event_offset    = out_reg.event_offset;
    assign out_ch.event_reading   = out_reg.event_reading;
    assign out_ch.event_threshold = out_reg.event_threshold;
    assign out_ch.asserted_out    = out_reg.asserted_out;
    assign out_ch.context_out     = out_reg.context_out;
    assign out_ch.last            = out_reg.last;

endmodule

// File: design/threshold_event_generator.sv
// channel   dir  handshake          payload
// in_ch     in   valid/ready        kind reading context_in forced_asserts forced_deasserts
// out_ch    out  valid/ready        is_event direction event_offset event_reading
//                                   event_threshold asserted_out context_out last
// apb       in   psel/penable, pready=1   paddr[5:3] selects register, 64-bit data
//
// an item is classified in the cycle it is accepted and queued (two entries)
// the back end sends one result per cycle unless out_ch stalls: n events then the status
// for each item, with n at most 24, found by the serial event scan in the back end
// input accepts while the queue has room, even when the output is stalled
// rst_n clears state, queue and output valid asynchronously
module threshold_event_generator
    import tev_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    tev_in_if.sink                in_ch,
    tev_out_if.source             out_ch
);

    cfg_t  cfg;
    logic  push_valid;
    logic  push_ready;
    work_t push_data;
    logic  head_valid;
    work_t head;
    logic  pop;

    tev_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tev_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .in_ch      (in_ch),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    tev_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (head_valid),
        .pop        (pop),
        .pop_data   (head)
    );

    tev_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .threshold_levels (cfg.threshold_levels),
        .head_valid       (head_valid),
        .head             (head),
        .pop              (pop),
        .out_ch           (out_ch)
    );

endmodule

// File: tb/threshold_event_generator_tb.sv
`timescale 1ns / 1ps

module threshold_event_generator_tb;
    import tev_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic pready;

    tev_in_if in_ch ();
    tev_out_if out_ch ();

    threshold_event_generator u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_ch),
        .out_ch  (out_ch)
    );

    always #5 clk = ~clk;

    cfg_t        shadow_cfg;
    logic [11:0] asserted_state;
    logic [11:0] ctx_state;
    logic [11:0] ctx_pick;
    result_t     pending_results[$];
    int          mismatch_count = 0;
    int          results_seen = 0;
    int          gap_pct = 0;
    int          stall_pct = 0;

    task automatic report_mismatch(string msg);
        if (mismatch_count < 50)
            $display("mismatch: %s", msg);
        mismatch_count++;
    endtask

    task automatic check_field(string name, logic [11:0] got, logic [11:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s got %0h want %0h",
                                      results_seen, name, got, want));
    endtask

    function automatic void expect_result(result_t r);
        pending_results.insert(pending_results.size(), r);
    endfunction

    // threshold scan over in-context offsets, returns the new asserted bits
    function automatic logic [11:0] scan_offsets(logic [11:0] st, logic [11:0] ctx,
                                                 logic [7:0] rd, logic [11:0] fa,
                                                 logic [11:0] fd, bit record);
        int          thr;
        int          hy;
        int          val;
        bit          as;
        bit          de;
        logic [11:0] en_as;
        logic [11:0] en_de;
        result_t     ev;
        en_as = shadow_cfg.supported_assert_mask & shadow_cfg.enabled_assert_mask;
        en_de = shadow_cfg.supported_deassert_mask & shadow_cfg.enabled_deassert_mask;
        for (int b = 0; b < NUM_OFFSETS; b++)
        begin
            if (!ctx[b])
                continue;
            thr = shadow_cfg.threshold_levels[8*(b/2) +: 8];
            val = rd;
            if (b % 2 == 1)
            begin
                hy = shadow_cfg.hysteresis_levels[15:8];
                as = val >= thr;
                de = val < thr - hy;
            end
            else
            begin
                hy = shadow_cfg.hysteresis_levels[7:0];
                as = val <= thr;
                de = val > thr + hy;
            end
            if (st[b])
                as = 1'b0;
            else
                de = 1'b0;
            if (as)
                st[b] = 1'b1;
            if (de)
                st[b] = 1'b0;
            if (record)
            begin
                ev = '0;
                ev.is_event = 1'b1;
                ev.event_offset = 4'(b);
                ev.event_reading = rd;
                ev.event_threshold = 8'(thr);
                if ((de || fd[b]) && en_de[b])
                begin
                    ev.direction = DIR_DEASSERT;
                    expect_result(ev);
                end
                if ((as || fa[b]) && en_as[b])
                begin
                    ev.direction = DIR_ASSERT;
                    expect_result(ev);
                end
            end
        end
        return st;
    endfunction

    function automatic void predict_sample(logic [1:0] kind, logic [7:0] rd, logic [11:0] ctx,
                                           logic [11:0] fa, logic [11:0] fd);
        logic [11:0] nomz;
        logic [11:0] nominal;
        logic [11:0] blips;
        result_t     status;
        case (kind)
            KIND_UNAVAIL:
                ctx_state = '0;
            KIND_REARM:
            begin
                asserted_state = '0;
                ctx_state = '0;
            end
            KIND_READING:
            begin
                if (ctx_state != ctx)
                begin
                    nomz = (ctx_state ^ ctx) | ~ctx;
                    if (shadow_cfg.nominal_override != OVERRIDE_UNSET)
                        nominal = shadow_cfg.nominal_override[11:0];
                    else if (shadow_cfg.nominal_reading < NOMINAL_UNSPEC)
                        nominal = scan_offsets('0, MASK12, shadow_cfg.nominal_reading[7:0],
                                               '0, '0, 1'b0);
                    else
                        nominal = DEFAULT_NOMINAL;
                    ctx_state = ctx;
                    asserted_state = (asserted_state & ~nomz) | (nomz & nominal);
                end
                blips = fa & fd;
                asserted_state = scan_offsets(asserted_state, ctx_state, rd,
                                              fa & (blips | ~asserted_state),
                                              fd & (blips | asserted_state), 1'b1);
            end
            default:
                ;
        endcase
        status = '0;
        status.asserted_out = asserted_state;
        status.context_out = ctx_state;
        status.last = 1'b1;
        expect_result(status);
    endfunction

    task automatic send_sample(logic [1:0] kind, logic [7:0] rd, logic [11:0] ctx,
                               logic [11:0] fa, logic [11:0] fd);
        if (gap_pct != 0 && $urandom_range(99) < gap_pct)
        begin
            in_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < gap_pct);
        end
        in_ch.valid <= 1'b1;
        in_ch.kind <= kind;
        in_ch.reading <= rd;
        in_ch.context_in <= ctx;
        in_ch.forced_asserts <= fa;
        in_ch.forced_deasserts <= fd;
        do
            @(posedge clk);
        while (!in_ch.ready);
        predict_sample(kind, rd, ctx, fa, fd);
    endtask

    // waits until every expected result is out and the block has settled
    task automatic drain_outputs(int settle);
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [63:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (idx)
            REG_THRESHOLD_LEVELS:   shadow_cfg.threshold_levels = value[47:0];
            REG_HYSTERESIS_LEVELS:  shadow_cfg.hysteresis_levels = value[15:0];
            REG_SUPPORTED_ASSERT:   shadow_cfg.supported_assert_mask = value[11:0];
            REG_SUPPORTED_DEASSERT: shadow_cfg.supported_deassert_mask = value[11:0];
            REG_ENABLED_ASSERT:     shadow_cfg.enabled_assert_mask = value[11:0];
            REG_ENABLED_DEASSERT:   shadow_cfg.enabled_deassert_mask = value[11:0];
            REG_NOMINAL_OVERRIDE:   shadow_cfg.nominal_override = value[15:0];
            REG_NOMINAL_READING:    shadow_cfg.nominal_reading = value[8:0];
            default:                ;
        endcase
    endtask

    task automatic program_config(cfg_t c);
        write_reg(REG_THRESHOLD_LEVELS, 64'(c.threshold_levels));
        write_reg(REG_HYSTERESIS_LEVELS, 64'(c.hysteresis_levels));
        write_reg(REG_SUPPORTED_ASSERT, 64'(c.supported_assert_mask));
        write_reg(REG_SUPPORTED_DEASSERT, 64'(c.supported_deassert_mask));
        write_reg(REG_ENABLED_ASSERT, 64'(c.enabled_assert_mask));
        write_reg(REG_ENABLED_DEASSERT, 64'(c.enabled_deassert_mask));
        write_reg(REG_NOMINAL_OVERRIDE, 64'(c.nominal_override));
        write_reg(REG_NOMINAL_READING, 64'(c.nominal_reading));
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    function automatic cfg_t basic_cfg(logic [15:0] hyst, logic [15:0] ovr, logic [8:0] nrd);
        cfg_t c;
        c.threshold_levels = 48'hC0B0A0203040;
        c.hysteresis_levels = hyst;
        c.supported_assert_mask = MASK12;
        c.supported_deassert_mask = MASK12;
        c.enabled_assert_mask = MASK12;
        c.enabled_deassert_mask = MASK12;
        c.nominal_override = ovr;
        c.nominal_reading = nrd;
        return c;
    endfunction

    function automatic cfg_t extreme_cfg(bit high);
        cfg_t c;
        c.threshold_levels = high ? '1 : '0;
        c.hysteresis_levels = high ? '1 : '0;
        c.supported_assert_mask = high ? MASK12 : '0;
        c.supported_deassert_mask = high ? MASK12 : '0;
        c.enabled_assert_mask = high ? MASK12 : '0;
        c.enabled_deassert_mask = high ? MASK12 : '0;
        c.nominal_override = high ? 16'hFFFE : 16'h0000;
        c.nominal_reading = high ? 9'd255 : 9'd0;
        return c;
    endfunction

    function automatic logic [7:0] hyst_byte();
        int r;
        r = $urandom_range(99);
        if (r < 60)
            return 8'($urandom_range(8));
        else if (r < 80)
            return 8'($urandom);
        else
            return ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
    endfunction

    function automatic logic [11:0] mask_pick();
        return ($urandom_range(99) < 60) ? MASK12 : 12'($urandom);
    endfunction

    function automatic cfg_t random_cfg();
        cfg_t c;
        logic [7:0] lnc;
        logic [7:0] unc;
        if ($urandom_range(1) != 0)
        begin
            // ordered thresholds, lower non-recoverable lowest
            lnc = 8'h40 + 8'($urandom_range(32));
            unc = 8'hA0 + 8'($urandom_range(32));
            c.threshold_levels[7:0] = lnc;
            c.threshold_levels[15:8] = lnc - 8'($urandom_range(24, 1));
            c.threshold_levels[23:16] = c.threshold_levels[15:8] - 8'($urandom_range(24, 1));
            c.threshold_levels[31:24] = unc;
            c.threshold_levels[39:32] = unc + 8'($urandom_range(24, 1));
            c.threshold_levels[47:40] = c.threshold_levels[39:32] + 8'($urandom_range(24, 1));
        end
        else
        begin
            for (int t = 0; t < 6; t++)
                c.threshold_levels[8*t +: 8] = ($urandom_range(4) == 0)
                    ? (($urandom_range(1) != 0) ? 8'hFF : 8'h00) : 8'($urandom);
        end
        c.hysteresis_levels = {hyst_byte(), hyst_byte()};
        c.supported_assert_mask = mask_pick();
        c.supported_deassert_mask = mask_pick();
        c.enabled_assert_mask = mask_pick();
        c.enabled_deassert_mask = mask_pick();
        c.nominal_override = ($urandom_range(1) != 0) ? OVERRIDE_UNSET : 16'($urandom);
        c.nominal_reading = ($urandom_range(99) < 40) ? NOMINAL_UNSPEC : 9'($urandom_range(255));
        return c;
    endfunction

    task automatic test_reset_defaults();
        send_sample(KIND_READING, 8'h80, MASK12, '0, '0);
        send_sample(KIND_READING, 8'h00, MASK12, '0, '0);
        send_sample(KIND_READING, 8'hFF, MASK12, '0, '0);
        drain_outputs(8);
    endtask

    task automatic test_threshold_crossings();
        program_config(basic_cfg(16'h0404, OVERRIDE_UNSET, NOMINAL_UNSPEC));
        send_sample(KIND_READING, 8'h80, MASK12, '0, '0);
        send_sample(KIND_READING, 8'h40, MASK12, '0, '0);
        send_sample(KIND_READING, 8'h44, MASK12, '0, '0);
        send_sample(KIND_READING, 8'h45, MASK12, '0, '0);
        send_sample(KIND_READING, 8'h20, MASK12, '0, '0);
        send_sample(KIND_READING, 8'h25, MASK12, '0, '0);
        send_sample(KIND_READING, 8'hC0, MASK12, '0, '0);
        send_sample(KIND_READING, 8'hBC, MASK12, '0, '0);
        send_sample(KIND_READING, 8'hBB, MASK12, '0, '0);
        send_sample(KIND_READING, 8'h80, MASK12, '0, '0);
        drain_outputs(8);
    endtask

    task automatic test_reading_kinds();
        send_sample(KIND_UNAVAIL, 8'h55, MASK12, '0, '0);
        send_sample(KIND_READING, 8'h30, MASK12, '0, '0);
        send_sample(KIND_REARM, 8'h30, MASK12, MASK12, MASK12);
        send_sample(KIND_UNUSED, 8'hAA, 12'hAAA, 12'h555, 12'hAAA);
        send_sample(KIND_READING, 8'hB0, 12'h0F0, '0, '0);
        drain_outputs(8);
    endtask

    task automatic test_forced_and_nominal();
        cfg_t c;
        c = basic_cfg(16'h0202, 16'h0555, NOMINAL_UNSPEC);
        c.enabled_assert_mask = 12'hF0F;
        c.enabled_deassert_mask = 12'h0FF;
        program_config(c);
        send_sample(KIND_READING, 8'h80, MASK12, MASK12, MASK12);
        send_sample(KIND_READING, 8'h80, MASK12, MASK12, '0);
        send_sample(KIND_READING, 8'h80, MASK12, '0, MASK12);
        send_sample(KIND_READING, 8'h38, 12'h3C3, 12'h00F, 12'h0F0);
        drain_outputs(8);
        program_config(basic_cfg(16'h0202, OVERRIDE_UNSET, 9'h010));
        send_sample(KIND_READING, 8'h80, MASK12, '0, '0);
        drain_outputs(8);
    endtask

    task automatic random_items(int count);
        logic [1:0]  k;
        logic [7:0]  rd;
        logic [11:0] fa;
        logic [11:0] fd;
        logic [11:0] m;
        int          r;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(99);
            if (r < 82)
                k = KIND_READING;
            else if (r < 89)
                k = KIND_UNAVAIL;
            else if (r < 95)
                k = KIND_REARM;
            else
                k = KIND_UNUSED;
            if ($urandom_range(99) < 25)
                ctx_pick = ($urandom_range(1) != 0) ? MASK12 : 12'($urandom);
            if ($urandom_range(1) != 0)
                rd = shadow_cfg.threshold_levels[8*$urandom_range(5) +: 8]
                     + 8'($urandom_range(8)) - 8'd4;
            else
                rd = 8'($urandom);
            r = $urandom_range(99);
            fa = '0;
            fd = '0;
            if (r >= 85)
            begin
                // blips in some offsets plus stray forced bits
                m = 12'($urandom);
                fa = m | (12'($urandom) & 12'($urandom));
                fd = m | (12'($urandom) & 12'($urandom));
            end
            else if (r >= 70)
            begin
                fa = 12'($urandom);
                fd = 12'($urandom);
            end
            send_sample(k, rd, ctx_pick, fa, fd);
        end
    endtask

    task automatic test_random_traffic();
        int gaps[4]   = '{0, 55, 0, 25};
        int stalls[4] = '{0, 0, 55, 25};
        for (int p = 0; p < 4; p++)
        begin
            for (int s = 0; s < 3; s++)
            begin
                drain_outputs(8);
                gap_pct = gaps[p];
                stall_pct = stalls[p];
                if (p == 0 && s < 2)
                    program_config(extreme_cfg(s == 1));
                else
                    program_config(random_cfg());
                random_items(35);
            end
        end
    endtask

    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch($sformatf("result %0d with nothing expected", results_seen));
            else
            begin
                want = pending_results.pop_front();
                check_field("is_event", out_ch.is_event, want.is_event);
                check_field("direction", out_ch.direction, want.direction);
                check_field("event_offset", out_ch.event_offset, want.event_offset);
                check_field("event_reading", out_ch.event_reading, want.event_reading);
                check_field("event_threshold", out_ch.event_threshold, want.event_threshold);
                check_field("asserted_out", out_ch.asserted_out, want.asserted_out);
                check_field("context_out", out_ch.context_out, want.context_out);
                check_field("last", out_ch.last, want.last);
            end
            results_seen++;
        end
        out_ch.ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
    end

    initial
    begin
        #(5_000_000);
        $display("[threshold_event_generator] ERROR");
        $finish;
    end

    initial
    begin
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        in_ch.valid <= 1'b0;
        in_ch.kind <= KIND_READING;
        in_ch.reading <= '0;
        in_ch.context_in <= '0;
        in_ch.forced_asserts <= '0;
        in_ch.forced_deasserts <= '0;
        shadow_cfg.threshold_levels = THRESHOLD_RESET;
        shadow_cfg.hysteresis_levels = '0;
        shadow_cfg.supported_assert_mask = MASK12;
        shadow_cfg.supported_deassert_mask = MASK12;
        shadow_cfg.enabled_assert_mask = MASK12;
        shadow_cfg.enabled_deassert_mask = MASK12;
        shadow_cfg.nominal_override = OVERRIDE_UNSET;
        shadow_cfg.nominal_reading = NOMINAL_UNSPEC;
        asserted_state = '0;
        ctx_state = '0;
        ctx_pick = MASK12;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_threshold_crossings();
        test_reading_kinds();
        test_forced_and_nominal();
        test_random_traffic();
        drain_outputs(30);

        if (mismatch_count == 0)
            $display("[threshold_event_generator] OK");
        else
            $display("[threshold_event_generator] ERROR");
        $finish;
    end

endmodule
